>>> design/conv2d_valid_window_assert.svh
// Assertion macros for the 2-D window correlator.
// Needs clk and arst_n in the scope that uses them.
`ifndef CONV2D_VALID_WINDOW_ASSERT_SVH
`define CONV2D_VALID_WINDOW_ASSERT_SVH

// same-cycle implication
`define CVW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CVW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/cvw_pkg.sv
// Types and codes for the 2-D window correlator.
// No dependencies.
`default_nettype none
package cvw_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} cvw_state_t;

	localparam logic OP_COEF  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [2:0] REG_IMG_W   = 3'd0;
	localparam logic [2:0] REG_IMG_H   = 3'd1;
	localparam logic [2:0] REG_KER_W   = 3'd2;
	localparam logic [2:0] REG_KER_H   = 3'd3;
	localparam logic [2:0] REG_BIAS    = 3'd4;
	localparam logic [2:0] REG_ROW_OFS = 3'd5;
	localparam logic [2:0] REG_COL_OFS = 3'd6;

endpackage
`default_nettype wire

>>> design/conv2d_valid_window.sv
// Streaming 2-D correlation over valid window positions, one shared MAC.
// Depends on cvw_pkg and conv2d_valid_window_assert.svh.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  op, coef_index, sample
//   out      source     out_valid/out_stall conv_value, out_index, out_of_range, last
//   cfg      APB slave  psel/penable/pready paddr, pwdata, prdata
//
// A coefficient load or a pixel that completes no window is taken in ST_IDLE and leaves
// the block idle. A pixel that completes a window runs ST_MAC, ST_DRAIN and ST_DONE,
// with one line store read and one multiply per tap through the shared MAC.
// Reset clears control state only; memories are undefined until written.
// A finished result waits in the output register; a stalled output holds the
// block at its final step until the register frees.
`default_nettype none
module conv2d_valid_window #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_KERNEL = 7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [5:0]         coef_index,
	input  wire logic signed [15:0] sample,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      conv_value,
	output logic [20:0]             out_index,
	output logic                    out_of_range,
	output logic                    last,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int KW    = $clog2(MAX_KERNEL + 1);
	localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
	localparam int TA    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int LA    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_HEIGHT + 8);
	localparam int IW    = WW + RW;
	localparam int AREA_W = WW + HW;
	localparam int IDX_W = (IW + 1 > 21) ? IW + 1 : 21;
	localparam int AW    = 33 + $clog2(TAPS + 1);

	cvw_pkg::cvw_state_t state_q, state_d;

	logic [10:0]        img_w_q, img_h_q;
	logic [2:0]         ker_w_q, ker_h_q, row_ofs_q, col_ofs_q;
	logic signed [31:0] bias_q;

	logic signed [15:0] line_mem [DEPTH];
	logic signed [15:0] coef_mem [TAPS];

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [SW-1:0] wslot_q;

	logic [XW-1:0] x0_q;
	logic [YW-1:0] y0_q;
	logic [SW-1:0] yslot_q;
	logic [KW-1:0] i_q, j_q;
	logic [TA-1:0] tap_q;
	logic          last_q;

	logic signed [15:0] pix_s1, coef_s1;
	logic               valid_s1;
	logic signed [31:0] prod_s2;
	logic               valid_s2;
	logic signed [AW-1:0] acc_q;
	logic [IW-1:0]      base_q;
	logic [AREA_W-1:0]  area_q;

	logic signed [31:0] conv_q;
	logic [20:0]        idx_out_q;
	logic               oor_q, last_out_q, out_valid_q;

	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [KW-1:0] kw, kh;

	logic cfg_wr, in_acc, pix_acc, win_hit, restart, mac_end, out_free;
	logic [XW-1:0] c_g;
	logic [YW-1:0] r_g;
	logic [SW-1:0] slot_g;
	logic [WW-1:0] c_inc;
	logic [HW-1:0] r_inc;
	logic [SW:0]   ysl_tmp;
	logic [IDX_W-1:0] idx_full;
	logic          sat_ok;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != cvw_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pix_acc  = in_acc && (op == cvw_pkg::OP_PIXEL);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (img_w_q == '0) w = WW'(1);
		else if (32'(img_w_q) > MAX_WIDTH) w = WW'(MAX_WIDTH);
		else w = WW'(img_w_q);
		if (img_h_q == '0) h = HW'(1);
		else if (32'(img_h_q) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
		else h = HW'(img_h_q);
		if (ker_w_q == '0) kw = KW'(1);
		else if (32'(ker_w_q) > MAX_KERNEL) kw = KW'(MAX_KERNEL);
		else kw = KW'(ker_w_q);
		if (ker_h_q == '0) kh = KW'(1);
		else if (32'(ker_h_q) > MAX_KERNEL) kh = KW'(MAX_KERNEL);
		else kh = KW'(ker_h_q);
	end

	// stale position after a geometry change restarts the raster
	always_comb begin
		restart = (WW'(col_q) >= w) || (HW'(row_q) >= h);
		c_g     = restart ? '0 : col_q;
		r_g     = restart ? '0 : row_q;
		slot_g  = restart ? '0 : wslot_q;
		c_inc   = WW'(c_g) + WW'(1);
		r_inc   = HW'(r_g) + HW'(1);
		win_hit = (WW'(kw) <= w) && (HW'(kh) <= h) && (r_inc >= HW'(kh)) && (c_inc >= WW'(kw));
		if ({1'b0, slot_g} >= (SW + 1)'(kh - KW'(1)))
			ysl_tmp = {1'b0, slot_g} - (SW + 1)'(kh - KW'(1));
		else
			ysl_tmp = {1'b0, slot_g} + (SW + 1)'(MAX_KERNEL) - (SW + 1)'(kh - KW'(1));
		mac_end = (i_q == kh - KW'(1)) && (j_q == kw - KW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cvw_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cvw_pkg::ST_IDLE:  if (pix_acc && win_hit) state_d = cvw_pkg::ST_MAC;
			cvw_pkg::ST_MAC:   if (mac_end) state_d = cvw_pkg::ST_DRAIN;
			cvw_pkg::ST_DRAIN: if (!valid_s1 && !valid_s2) state_d = cvw_pkg::ST_DONE;
			cvw_pkg::ST_DONE:  if (out_free) state_d = cvw_pkg::ST_IDLE;
			default:           state_d = cvw_pkg::ST_IDLE;
		endcase
	end

	// configuration registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q   <= 11'd1024;
			img_h_q   <= 11'd1024;
			ker_w_q   <= 3'd3;
			ker_h_q   <= 3'd3;
			bias_q    <= '0;
			row_ofs_q <= '0;
			col_ofs_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			wslot_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				cvw_pkg::REG_IMG_W: begin
					img_w_q <= pwdata[10:0];
					col_q <= '0; row_q <= '0; wslot_q <= '0;
				end
				cvw_pkg::REG_IMG_H: begin
					img_h_q <= pwdata[10:0];
					col_q <= '0; row_q <= '0; wslot_q <= '0;
				end
				cvw_pkg::REG_KER_W: begin
					ker_w_q <= pwdata[2:0];
					col_q <= '0; row_q <= '0; wslot_q <= '0;
				end
				cvw_pkg::REG_KER_H: begin
					ker_h_q <= pwdata[2:0];
					col_q <= '0; row_q <= '0; wslot_q <= '0;
				end
				cvw_pkg::REG_BIAS:    bias_q <= pwdata;
				cvw_pkg::REG_ROW_OFS: row_ofs_q <= pwdata[2:0];
				cvw_pkg::REG_COL_OFS: col_ofs_q <= pwdata[2:0];
				default: ;
			endcase
		end else if (pix_acc) begin
			if (c_inc >= w) begin
				col_q <= '0;
				if (r_inc >= h) begin
					row_q   <= '0;
					wslot_q <= '0;
				end else begin
					row_q   <= YW'(r_inc);
					wslot_q <= (32'(slot_g) == MAX_KERNEL - 1) ? '0 : slot_g + SW'(1);
				end
			end else begin
				col_q <= XW'(c_inc);
			end
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			cvw_pkg::REG_IMG_W:   prdata = {21'd0, img_w_q};
			cvw_pkg::REG_IMG_H:   prdata = {21'd0, img_h_q};
			cvw_pkg::REG_KER_W:   prdata = {29'd0, ker_w_q};
			cvw_pkg::REG_KER_H:   prdata = {29'd0, ker_h_q};
			cvw_pkg::REG_BIAS:    prdata = bias_q;
			cvw_pkg::REG_ROW_OFS: prdata = {29'd0, row_ofs_q};
			cvw_pkg::REG_COL_OFS: prdata = {29'd0, col_ofs_q};
			default:              prdata = '0;
		endcase
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (pix_acc)
			line_mem[LA'(slot_g) * LA'(MAX_WIDTH) + LA'(c_g)] <= sample;
		if (in_acc && op == cvw_pkg::OP_COEF && 32'(coef_index) < TAPS)
			coef_mem[TA'(coef_index)] <= sample;
		pix_s1  <= line_mem[LA'(yslot_q) * LA'(MAX_WIDTH) + LA'(x0_q) + LA'(j_q)];
		coef_s1 <= coef_mem[tap_q];
		prod_s2 <= pix_s1 * coef_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == cvw_pkg::ST_MAC);
			valid_s2 <= valid_s1;
		end
	end

	// window sequencer and accumulator
	always_ff @(posedge clk) begin
		if (state_q == cvw_pkg::ST_IDLE && pix_acc) begin
			x0_q    <= XW'(c_inc - WW'(kw));
			y0_q    <= YW'(r_inc - HW'(kh));
			yslot_q <= SW'(ysl_tmp);
			i_q     <= '0;
			j_q     <= '0;
			tap_q   <= '0;
			last_q  <= (r_inc == h) && (c_inc == w);
			acc_q   <= AW'(bias_q);
		end else begin
			if (state_q == cvw_pkg::ST_MAC) begin
				tap_q  <= tap_q + TA'(1);
				base_q <= IW'(w) * IW'(RW'(y0_q) + RW'(row_ofs_q));
				area_q <= AREA_W'(w) * AREA_W'(h);
				if (j_q == kw - KW'(1)) begin
					j_q     <= '0;
					i_q     <= i_q + KW'(1);
					yslot_q <= (32'(yslot_q) == MAX_KERNEL - 1) ? '0 : yslot_q + SW'(1);
				end else begin
					j_q <= j_q + KW'(1);
				end
			end
			if (valid_s2)
				acc_q <= acc_q + AW'(prod_s2);
		end
	end

	assign idx_full = IDX_W'(base_q) + IDX_W'(x0_q) + IDX_W'(col_ofs_q);
	assign sat_ok   = (acc_q[AW-1:31] == '0) || (acc_q[AW-1:31] == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == cvw_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == cvw_pkg::ST_DONE && out_free) begin
			if (sat_ok) conv_q <= acc_q[31:0];
			else conv_q <= acc_q[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			idx_out_q  <= idx_full[20:0];
			oor_q      <= (idx_full >= IDX_W'(area_q));
			last_out_q <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign conv_value   = conv_q;
	assign out_index    = idx_out_q;
	assign out_of_range = oor_q;
	assign last         = last_out_q;

`include "conv2d_valid_window_assert.svh"

	`CVW_ASSERT_NOW(a_idle_pipe_empty, state_q == cvw_pkg::ST_IDLE, !valid_s1 && !valid_s2)
	`CVW_ASSERT_NEXT(a_done_holds, state_q == cvw_pkg::ST_DONE && out_valid_q && out_stall,
		state_q == cvw_pkg::ST_DONE)
	`CVW_ASSERT_NOW(a_tap_in_range, state_q == cvw_pkg::ST_MAC, 32'(tap_q) < TAPS)

endmodule
`default_nettype wire
